// ----- rtl/bpn_pkg.sv -----
// Shared types and constants for the block peak normalizer.
`default_nettype none

package bpn_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int PCM_W    = 16;

    // Scale: pcm = |s| * SCALE_NUM / (SCALE_DEN * peak)
    localparam int SCALE_W   = 20;
    localparam logic [SCALE_W-1:0] SCALE_NUM = SCALE_W'(622573);
    localparam int DEN_W     = 28;
    localparam logic [DEN_W-1:0] SCALE_DEN = DEN_W'(20);
    localparam int NUM_W     = SAMPLE_W + SCALE_W;
    localparam logic [PCM_W-1:0] PCM_LIMIT = PCM_W'(32767);

    // Divider: 16 quotient bits, two bits per cycle
    localparam int Q_W      = 16;
    localparam int DIV_CYC  = Q_W / 2;
    localparam int DCNT_W   = $clog2(DIV_CYC);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_PUT
    } bpn_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // store accepted sample, update peak, bump fill
        logic rd;        // issue store read at current index
        logic mul;       // scale stored sample, set up divider
        logic div_step;  // two quotient bits
        logic put;       // move result into output register
        logic advance;   // next index
        logic close;     // end of block: clear fill, index and peak
    } bpn_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic close_hit;  // input request closes the block
        logic div_done;   // final divider cycle
        logic last_idx;   // current index is the block's final sample
        logic out_free;   // output register can take a result
    } bpn_stat_t;

endpackage

`default_nettype wire

// ----- rtl/bpn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bpn_ctrl.sv -----
// Sequencing state machine for load and emit phases.
`default_nettype none

module bpn_ctrl
    import bpn_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire bpn_stat_t stat,
    output bpn_cmd_t       cmd
);

    bpn_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (stat.close_hit) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                // hold until the output register frees up
                if (stat.out_free) begin
                    cmd.put = 1'b1;
                    if (stat.last_idx) begin
                        cmd.close  = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/bpn_dp.sv -----
// Datapath: sample store, peak tracking, scaling multiplier, divider, output register.
`default_nettype none

module bpn_dp
    import bpn_pkg::*;
#(
    parameter int BLOCK_DEPTH = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bpn_cmd_t            cmd,
    output bpn_stat_t                stat,
    input  wire logic [SAMPLE_W-1:0] in_sample,
    input  wire logic                in_last,
    output logic [PCM_W-1:0]         m_tdata,
    output logic                     m_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready
);

    localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(BLOCK_DEPTH - 1);

    logic [AW-1:0]       fill_reg;
    logic [AW-1:0]       idx_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic [SAMPLE_W-1:0] in_mag;
    logic [SAMPLE_W-1:0] rd_data;
    logic [SAMPLE_W-1:0] rd_mag;

    logic [NUM_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    dsh_reg;
    logic [Q_W-1:0]      q_reg;
    logic [DCNT_W-1:0]   dcnt_reg;
    logic                ovf_reg;
    logic                neg_reg;
    logic                zero_reg;

    logic [DEN_W-1:0]    den;
    logic                ge1, ge2;
    logic [NUM_W-1:0]    rem1, rem2;
    logic [NUM_W-1:0]    dsh1;
    logic [PCM_W-1:0]    mag_out;
    logic [PCM_W-1:0]    pcm_out;

    // Magnitudes of incoming and stored samples
    assign in_mag = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
    assign rd_mag = rd_data[SAMPLE_W-1] ? (~rd_data + 1'b1) : rd_data;

    bpn_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(BLOCK_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (fill_reg),
        .wdata (in_sample),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Fill count, emit index and peak
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            idx_reg  <= '0;
            peak_reg <= '0;
        end else if (cmd.close) begin
            fill_reg <= '0;
            idx_reg  <= '0;
            peak_reg <= '0;
        end else begin
            if (cmd.load) begin
                // keep fill at the closing slot: it marks the last index while emitting
                if (!stat.close_hit) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (in_mag > peak_reg) begin
                    peak_reg <= in_mag;
                end
            end
            if (cmd.advance) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign den = DEN_W'(peak_reg) * SCALE_DEN;

    // Restoring division, two quotient bits per cycle
    always_comb begin
        ge1  = rem_reg >= dsh_reg;
        rem1 = ge1 ? (rem_reg - dsh_reg) : rem_reg;
        dsh1 = dsh_reg >> 1;
        ge2  = rem1 >= dsh1;
        rem2 = ge2 ? (rem1 - dsh1) : rem1;
    end

    // Multiplier and divider registers
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            rem_reg  <= NUM_W'(rd_mag) * NUM_W'(SCALE_NUM);
            dsh_reg  <= NUM_W'(den) << (Q_W - 1);
            q_reg    <= '0;
            neg_reg  <= rd_data[SAMPLE_W-1];
            zero_reg <= (peak_reg == '0);
        end else if (cmd.div_step) begin
            rem_reg <= rem2;
            dsh_reg <= dsh1 >> 1;
            q_reg   <= {q_reg[Q_W-3:0], ge1, ge2};
            if (dcnt_reg == '0) begin
                // quotient would not fit in Q_W bits
                ovf_reg <= (rem_reg >> 1) >= dsh_reg;
            end
        end
    end

    // Divider cycle count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.mul) begin
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // Clamp, restore sign, zero for a silent block
    always_comb begin
        mag_out = (ovf_reg || q_reg[Q_W-1]) ? PCM_LIMIT : PCM_W'(q_reg);
        if (zero_reg) begin
            pcm_out = '0;
        end else if (neg_reg) begin
            pcm_out = ~mag_out + 1'b1;
        end else begin
            pcm_out = mag_out;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.put) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put) begin
            m_tdata <= pcm_out;
            m_tlast <= stat.last_idx;
        end
    end

    // Status to controller
    always_comb begin
        stat.close_hit = in_last || (fill_reg == LAST_SLOT);
        stat.div_done  = (dcnt_reg == DCNT_W'(DIV_CYC - 1));
        stat.last_idx  = (idx_reg == fill_reg);
        stat.out_free  = !m_tvalid || m_tready;
    end

endmodule

`default_nettype wire

// ----- rtl/block_peak_normalizer_pcm16_core.sv -----
// Top level of the block peak normalizer: controller, datapath and checks.
//
// Input stream (s_): tdata[23:0] is a signed Q1.23 sample, tlast closes the
// block. Samples are stored and the block's peak magnitude is tracked, one
// request per cycle while loading. A block closes on tlast or when
// BLOCK_DEPTH samples are held. The block then stops taking input and emits
// every stored sample in arrival order on the result stream (m_): tdata[15:0]
// is signed PCM, scaled so the peak lands at 0.95 of full scale, truncated
// toward zero; tlast marks the block's final result. A silent block emits 0s.
// Emit steps per sample: a store read, a multiply, the divider steps (two
// quotient bits each) and an output load. Each sample passes through the
// single serial divider; the next sample starts only after the current
// result is loaded.
// A stalled receiver holds the current result in the output register and
// the next result waits in the divider; after the final result is loaded,
// loading of the next block starts at once.
// Reset (aresetn low, synchronous) empties the block, clears the peak and
// drops any pending result; the sample store itself is not cleared.
`default_nettype none

module block_peak_normalizer_pcm16_core
    import bpn_pkg::*;
#(
    parameter int BLOCK_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [23:0] sample
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] pcm
    output logic             m_tlast
);

    bpn_cmd_t  cmd;
    bpn_stat_t stat;

    bpn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpn_dp #(
        .BLOCK_DEPTH(BLOCK_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_sample (s_tdata[SAMPLE_W-1:0]),
        .in_last   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

`ifndef NO_ASSERTIONS
    // Clamp keeps the result inside +-32767
    a_pcm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != 16'h8000))
        else $error("pcm result outside clamp range");

    // No new result starts while loading
    a_no_emit_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("result produced during load phase");

    // Final result of a block returns control to loading
    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put && stat.last_idx) |=> (s_tready && m_tvalid && m_tlast))
        else $error("block end did not reopen input");

    // At most one of load, rd, mul, div_step and put per cycle
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.rd, cmd.mul, cmd.div_step, cmd.put}))
        else $error("overlapping datapath commands");
`endif

endmodule

`default_nettype wire
